// File: hw/rtl/frt_pkg.sv
`timescale 1ns / 1ps

package frt_pkg;

    localparam int PIX_W  = 16;
    localparam int WID_W  = 10;
    localparam int HGT_W  = 9;
    localparam int ROW_W  = 8;
    localparam int COL_W  = 9;
    localparam int OFF_W  = 17;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic [WID_W-1:0] MAX_WIDTH    = 10'd512;
    localparam logic [HGT_W-1:0] MAX_HEIGHT   = 9'd256;
    localparam logic [WID_W-1:0] RESET_WIDTH  = 10'd384;
    localparam logic [HGT_W-1:0] RESET_HEIGHT = 9'd224;

    typedef enum logic
    {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef struct packed
    {
        logic [WID_W-1:0] width;
        logic [HGT_W-1:0] height;
    } cfg_t;

    typedef struct packed
    {
        logic [PIX_W-1:0] pix;
        logic             bank;
        logic             rd_en;
        logic             line_end;
        logic             frame_end;
        logic [ROW_W-1:0] wr_row;
        logic [COL_W-1:0] wr_col;
        logic [ROW_W-1:0] rd_col;
        logic [COL_W-1:0] src_col;
        logic [WID_W-1:0] width;
    } seq_req_t;

    typedef struct packed
    {
        logic [PIX_W-1:0] pix;
        logic             bank;
        logic             rd_en;
        logic             line_end;
        logic             frame_end;
        logic [OFF_W-1:0] wr_off;
        logic [OFF_W-1:0] rd_off;
    } addr_req_t;

endpackage

// File: hw/rtl/frt_seq.sv
`timescale 1ns / 1ps

module frt_seq
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  frt_pkg::cfg_t               cfg,
    input  logic                        accept,
    input  logic [frt_pkg::PIX_W-1:0]   pixel_in,
    output frt_pkg::seq_req_t           req
);
    import frt_pkg::*;

    logic [ROW_W-1:0] wr_row_reg, wr_row_next;
    logic [COL_W-1:0] wr_col_reg, wr_col_next;
    logic [COL_W-1:0] rd_row_reg, rd_row_next;
    logic [ROW_W-1:0] rd_col_reg, rd_col_next;
    logic             bank_reg, bank_next;
    logic             ready_reg, ready_next;

    logic [WID_W-1:0] width_eff;
    logic [HGT_W-1:0] height_eff;
    logic [WID_W-1:0] src_col_wide;
    logic             rd_col_last;
    logic             rd_row_last;
    logic             wr_col_last;
    logic             wr_row_last;

    always_comb
    begin
        // zero counts as one, oversize is clamped
        if (cfg.width == '0)
        begin
            width_eff = WID_W'(1);
        end
        else if (cfg.width > MAX_WIDTH)
        begin
            width_eff = MAX_WIDTH;
        end
        else
        begin
            width_eff = cfg.width;
        end

        if (cfg.height == '0)
        begin
            height_eff = HGT_W'(1);
        end
        else if (cfg.height > MAX_HEIGHT)
        begin
            height_eff = MAX_HEIGHT;
        end
        else
        begin
            height_eff = cfg.height;
        end

        if (WID_W'(rd_row_reg) < width_eff)
        begin
            src_col_wide = width_eff - WID_W'(1) - WID_W'(rd_row_reg);
        end
        else
        begin
            src_col_wide = '0;
        end

        rd_col_last = (HGT_W'(rd_col_reg) + HGT_W'(1)) >= height_eff;
        rd_row_last = (WID_W'(rd_row_reg) + WID_W'(1)) >= width_eff;
        wr_col_last = (WID_W'(wr_col_reg) + WID_W'(1)) >= width_eff;
        wr_row_last = (HGT_W'(wr_row_reg) + HGT_W'(1)) >= height_eff;
    end

    always_comb
    begin
        req.pix       = pixel_in;
        req.bank      = bank_reg;
        req.rd_en     = ready_reg;
        req.line_end  = rd_col_last;
        req.frame_end = rd_col_last && rd_row_last;
        req.wr_row    = wr_row_reg;
        req.wr_col    = wr_col_reg;
        req.rd_col    = rd_col_reg;
        req.src_col   = src_col_wide[COL_W-1:0];
        req.width     = width_eff;
    end

    always_comb
    begin
        wr_row_next = wr_row_reg;
        wr_col_next = wr_col_reg;
        rd_row_next = rd_row_reg;
        rd_col_next = rd_col_reg;
        bank_next   = bank_reg;
        ready_next  = ready_reg;

        if (accept)
        begin
            if (ready_reg)
            begin
                if (rd_col_last)
                begin
                    rd_col_next = '0;
                    rd_row_next = rd_row_last ? '0 : rd_row_reg + COL_W'(1);
                end
                else
                begin
                    rd_col_next = rd_col_reg + ROW_W'(1);
                end
            end

            if (wr_col_last)
            begin
                wr_col_next = '0;
                if (wr_row_last)
                begin
                    // frame complete: swap banks and restart read-out
                    wr_row_next = '0;
                    bank_next   = !bank_reg;
                    ready_next  = 1'b1;
                    rd_row_next = '0;
                    rd_col_next = '0;
                end
                else
                begin
                    wr_row_next = wr_row_reg + ROW_W'(1);
                end
            end
            else
            begin
                wr_col_next = wr_col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_row_reg <= '0;
            wr_col_reg <= '0;
            rd_row_reg <= '0;
            rd_col_reg <= '0;
            bank_reg   <= 1'b0;
            ready_reg  <= 1'b0;
        end
        else
        begin
            wr_row_reg <= wr_row_next;
            wr_col_reg <= wr_col_next;
            rd_row_reg <= rd_row_next;
            rd_col_reg <= rd_col_next;
            bank_reg   <= bank_next;
            ready_reg  <= ready_next;
        end
    end

endmodule

// File: hw/rtl/frt_addr.sv
`timescale 1ns / 1ps

module frt_addr
#(
    parameter int MAX_PIXELS = 131072
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  frt_pkg::seq_req_t    req,
    output logic                 out_valid,
    input  logic                 out_ready,
    output frt_pkg::addr_req_t   out_req
);
    import frt_pkg::*;

    // one conditional subtract of a scaled store size per reduction stage
    localparam int RED_STEPS = $clog2(((1 << OFF_W) + MAX_PIXELS - 1) / MAX_PIXELS);
    localparam int NS        = RED_STEPS + 1;

    addr_req_t        stg_reg [NS];
    addr_req_t        stg_next [NS];
    logic [NS-1:0]    vld_reg;
    logic [NS:0]      rdy;

    assign rdy[NS]   = out_ready;
    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[NS-1];
    assign out_req   = stg_reg[NS-1];

    genvar s;
    generate
        for (s = 0; s < NS; s++)
        begin : g_stage
            assign rdy[s] = !vld_reg[s] || rdy[s+1];

            if (s == 0)
            begin : g_mul
                always_comb
                begin
                    stg_next[s].pix       = req.pix;
                    stg_next[s].bank      = req.bank;
                    stg_next[s].rd_en     = req.rd_en;
                    stg_next[s].line_end  = req.line_end;
                    stg_next[s].frame_end = req.frame_end;
                    stg_next[s].wr_off    = OFF_W'(OFF_W'(req.wr_row) * OFF_W'(req.width))
                                            + OFF_W'(req.wr_col);
                    stg_next[s].rd_off    = OFF_W'(OFF_W'(req.rd_col) * OFF_W'(req.width))
                                            + OFF_W'(req.src_col);
                end

                always_ff @(posedge clk or negedge rst_n)
                begin
                    if (!rst_n)
                    begin
                        vld_reg[s] <= 1'b0;
                    end
                    else if (rdy[s])
                    begin
                        vld_reg[s] <= in_valid;
                    end
                end
            end
            else
            begin : g_red
                localparam logic [OFF_W-1:0] SUB = OFF_W'(MAX_PIXELS << (RED_STEPS - s));

                always_comb
                begin
                    stg_next[s] = stg_reg[s-1];
                    if (stg_reg[s-1].wr_off >= SUB)
                    begin
                        stg_next[s].wr_off = stg_reg[s-1].wr_off - SUB;
                    end
                    if (stg_reg[s-1].rd_off >= SUB)
                    begin
                        stg_next[s].rd_off = stg_reg[s-1].rd_off - SUB;
                    end
                end

                always_ff @(posedge clk or negedge rst_n)
                begin
                    if (!rst_n)
                    begin
                        vld_reg[s] <= 1'b0;
                    end
                    else if (rdy[s])
                    begin
                        vld_reg[s] <= vld_reg[s-1];
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (rdy[s])
                begin
                    stg_reg[s] <= stg_next[s];
                end
            end
        end
    endgenerate

endmodule

// File: hw/rtl/frt_store.sv
`timescale 1ns / 1ps

module frt_store
#(
    parameter int MAX_PIXELS = 131072,
    parameter int PIXEL_BITS = 16
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  frt_pkg::addr_req_t          in_req,
    output logic                        dst_valid,
    input  logic                        dst_stall,
    output logic [frt_pkg::PIX_W-1:0]   pixel_out,
    output logic                        line_end,
    output logic                        frame_end
);
    import frt_pkg::*;

    localparam int AW = $clog2(MAX_PIXELS);
    localparam int SW = (PIXEL_BITS < PIX_W) ? PIXEL_BITS : PIX_W;

    logic [SW-1:0] mem0 [MAX_PIXELS];
    logic [SW-1:0] mem1 [MAX_PIXELS];

    logic [SW-1:0] rd0_reg;
    logic [SW-1:0] rd1_reg;
    logic          sel_reg;
    logic          le_reg;
    logic          fe_reg;
    logic          out_valid_reg;

    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic [SW-1:0] wr_data;
    logic          take;

    assign in_ready = !out_valid_reg || !dst_stall;
    assign take     = in_valid && in_ready;
    assign wr_addr  = AW'(in_req.wr_off);
    assign rd_addr  = AW'(in_req.rd_off);
    assign wr_data  = SW'(in_req.pix);

    // bank 0
    always_ff @(posedge clk)
    begin
        if (take && !in_req.bank)
        begin
            mem0[wr_addr] <= wr_data;
        end
        if (take && in_req.rd_en && in_req.bank)
        begin
            rd0_reg <= mem0[rd_addr];
        end
    end

    // bank 1
    always_ff @(posedge clk)
    begin
        if (take && in_req.bank)
        begin
            mem1[wr_addr] <= wr_data;
        end
        if (take && in_req.rd_en && !in_req.bank)
        begin
            rd1_reg <= mem1[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && in_req.rd_en)
        begin
            sel_reg <= !in_req.bank;
            le_reg  <= in_req.line_end;
            fe_reg  <= in_req.frame_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= take && in_req.rd_en;
        end
    end

    assign dst_valid = out_valid_reg;
    assign pixel_out = PIX_W'(sel_reg ? rd1_reg : rd0_reg);
    assign line_end  = le_reg;
    assign frame_end = fe_reg;

endmodule

// File: hw/rtl/frame_rotate_270.sv
// frame_rotate_270: double-buffered 270 degree frame rotator
// source channel: src_valid / src_stall with pixel_in, one RGB565 pixel per
// request in raster order of a frame_width x frame_height frame
// result channel: dst_valid / dst_stall with pixel_out, line_end, frame_end;
// the rotated image is frame_height wide and frame_width tall
// while a frame is written into one bank, the previous frame is read out of
// the other bank, one rotated pixel for each source pixel; the first frame
// after reset gives no results
// throughput: one pixel per cycle while dst_stall is low, set by one write and
// one read port per bank; a request passes the address multiply stage, R
// address reduction stages and the store read register, where R is zero when
// MAX_PIXELS is at least 131072, else log2(131072 / MAX_PIXELS) rounded up
// reset clears the counters, the bank select and the frame-complete flag and
// sets width 384 and height 224; the frame store is not cleared
// when the receiver stalls, the result holds and requests keep flowing into
// the address pipeline until it is full, then src_stall rises
// config: APB, width at address 0, height at address 4, write only when idle
`timescale 1ns / 1ps

module frame_rotate_270
#(
    parameter int MAX_PIXELS = 131072,
    parameter int PIXEL_BITS = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [frt_pkg::ADDR_W-1:0]   paddr,
    input  logic [frt_pkg::DATA_W-1:0]   pwdata,
    output logic [frt_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    input  logic                         src_valid,
    output logic                         src_stall,
    input  logic [frt_pkg::PIX_W-1:0]    pixel_in,
    output logic                         dst_valid,
    input  logic                         dst_stall,
    output logic [frt_pkg::PIX_W-1:0]    pixel_out,
    output logic                         line_end,
    output logic                         frame_end
);
    import frt_pkg::*;

    logic [WID_W-1:0] width_reg;
    logic [HGT_W-1:0] height_reg;
    cfg_t             cfg;
    cfg_reg_t         reg_sel;
    logic             cfg_wr;

    seq_req_t         seq_req;
    addr_req_t        addr_req;
    logic             addr_ready;
    logic             addr_valid;
    logic             store_ready;
    logic             accept;

    assign pready  = 1'b1;
    assign reg_sel = cfg_reg_t'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RESET_WIDTH;
            height_reg <= RESET_HEIGHT;
        end
        else if (cfg_wr)
        begin
            unique case (reg_sel)
                REG_WIDTH:  width_reg  <= pwdata[WID_W-1:0];
                REG_HEIGHT: height_reg <= pwdata[HGT_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_WIDTH:  prdata = DATA_W'(width_reg);
            REG_HEIGHT: prdata = DATA_W'(height_reg);
        endcase
    end

    assign cfg.width  = width_reg;
    assign cfg.height = height_reg;

    assign src_stall = !addr_ready;
    assign accept    = src_valid && addr_ready;

    frt_seq u_seq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .accept   (accept),
        .pixel_in (pixel_in),
        .req      (seq_req)
    );

    frt_addr #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_addr
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (src_valid),
        .in_ready  (addr_ready),
        .req       (seq_req),
        .out_valid (addr_valid),
        .out_ready (store_ready),
        .out_req   (addr_req)
    );

    frt_store #(
        .MAX_PIXELS (MAX_PIXELS),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_store
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (addr_valid),
        .in_ready  (store_ready),
        .in_req    (addr_req),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .pixel_out (pixel_out),
        .line_end  (line_end),
        .frame_end (frame_end)
    );

endmodule

// File: hw/rtl/frt_check.sv
`timescale 1ns / 1ps

module frt_check
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [frt_pkg::ADDR_W-1:0]   paddr,
    input  logic [frt_pkg::DATA_W-1:0]   pwdata,
    input  logic [frt_pkg::DATA_W-1:0]   prdata,
    input  logic                         pready,
    input  logic                         src_valid,
    input  logic                         src_stall,
    input  logic [frt_pkg::PIX_W-1:0]    pixel_in,
    input  logic                         dst_valid,
    input  logic                         dst_stall,
    input  logic [frt_pkg::PIX_W-1:0]    pixel_out,
    input  logic                         line_end,
    input  logic                         frame_end
);
    import frt_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && dst_stall |=> dst_valid && $stable(pixel_out)
            && $stable(line_end) && $stable(frame_end))
        else $error("stalled result changed");

    // stalled request holds
    a_src_hold: assert property (@(posedge clk) disable iff (!rst_n)
        src_valid && src_stall |=> src_valid && $stable(pixel_in))
        else $error("stalled request changed");

    // the last pixel of a frame also closes a line
    a_frame_line: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && frame_end |-> line_end)
        else $error("frame end without line end");

    // nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge clk)
        $past(!rst_n) |-> !dst_valid)
        else $error("result right after reset");

    // a width write reads back at once
    a_width_back: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready && (cfg_reg_t'(paddr[2]) == REG_WIDTH)
        |=> !(psel && !pwrite && (cfg_reg_t'(paddr[2]) == REG_WIDTH))
            || (prdata == DATA_W'($past(pwdata[WID_W-1:0]))))
        else $error("width register read back wrong");

endmodule

bind frame_rotate_270 frt_check u_check (.*);
